[hdl/sacd_pkg.sv]
// Package for the set-associative cache directory.
// Default geometry and fixed widths; no dependencies.
`default_nettype none
package sacd_pkg;

  localparam int SET_BITS_DEF   = 6;
  localparam int WAY_BITS_DEF   = 2;
  localparam int BLOCK_BITS_DEF = 6;
  localparam int ADDR_BITS_DEF  = 32;

  localparam int          OUT_WAY_W  = 2;
  localparam int          LFSR_W     = 16;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam logic [15:0] LFSR_SEED  = 16'h0001;

endpackage
`default_nettype wire

[hdl/sacd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module sacd_ram #(
  parameter int WIDTH  = 20,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/set_assoc_cache_directory_top.sv]
// Top level of the set-associative write-back cache directory.
// Depends on sacd_pkg and sacd_ram (tag store).
//
//  channel | ports                       | direction | word
//  in      | in_valid / in_ready         | input     | command, address
//  out     | out_valid / out_ready       | output    | hit, way, writeback, fetch, blocks
//
// The tag store is one single-port RAM read one way at a time: each way probed
// takes a read state and a compare state. A hit stops at the matching way; a miss
// probes every way, then reads back a dirty victim's tag before the fill.
// Valid bits are flip-flops cleared by reset; each tag entry carries its dirty
// bit, which a fill writes along with setting the valid bit, so no clearing pass.
// A finished word waits in the output register; the next word may be taken
// meanwhile, and completion stalls only while that register is still full.
`default_nettype none
module set_assoc_cache_directory_top #(
  parameter int SET_BITS   = sacd_pkg::SET_BITS_DEF,
  parameter int WAY_BITS   = sacd_pkg::WAY_BITS_DEF,
  parameter int BLOCK_BITS = sacd_pkg::BLOCK_BITS_DEF,
  parameter int ADDR_BITS  = sacd_pkg::ADDR_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_command,
  input  wire logic [ADDR_BITS-1:0]             in_address,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_hit,
  output logic [sacd_pkg::OUT_WAY_W-1:0]        out_way,
  output logic                                  out_writeback,
  output logic [ADDR_BITS-BLOCK_BITS-1:0]       out_writeback_block,
  output logic                                  out_fetch,
  output logic [ADDR_BITS-BLOCK_BITS-1:0]       out_fetch_block,
  output logic                                  out_store_through
);
  import sacd_pkg::*;

  localparam int NUM_WAYS  = 1 << WAY_BITS;
  localparam int NUM_LINES = 1 << (SET_BITS + WAY_BITS);
  localparam int TAG_BITS  = ADDR_BITS - SET_BITS - BLOCK_BITS;
  localparam int TAG_W     = (TAG_BITS > 0) ? TAG_BITS : 1;
  localparam int ENT_W     = TAG_W + 1;
  localparam int SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WAY_W     = (WAY_BITS > 0) ? WAY_BITS : 1;
  localparam int LINE_W    = ((SET_BITS + WAY_BITS) > 0) ? (SET_BITS + WAY_BITS) : 1;
  localparam int BLK_W     = ADDR_BITS - BLOCK_BITS;
  localparam int WB_W      = TAG_W + SET_W;

  localparam logic [SET_W-1:0] SET_MASK = SET_W'((1 << SET_BITS) - 1);
  localparam logic [WAY_W-1:0] WAY_MASK = WAY_W'(NUM_WAYS - 1);
  localparam logic [WAY_W-1:0] WAY_LAST = WAY_W'(NUM_WAYS - 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PROBE  = 8'b0000_0010,
    S_CMP    = 8'b0000_0100,
    S_MISS   = 8'b0000_1000,
    S_VREAD  = 8'b0001_0000,
    S_VCAP   = 8'b0010_0000,
    S_FILL   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic                 is_write_r, is_write_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic [SET_W-1:0]     set_r, set_nxt;
  logic [BLK_W-1:0]     block_r, block_nxt;
  logic [WAY_W-1:0]     cur_way_r, cur_way_nxt;
  logic                 inv_found_r, inv_found_nxt;
  logic [WAY_W-1:0]     inv_way_r, inv_way_nxt;
  logic                 hit_r, hit_nxt;
  logic                 wb_r, wb_nxt;
  logic [BLK_W-1:0]     wb_block_r, wb_block_nxt;
  logic [LFSR_W-1:0]    lfsr_r, lfsr_nxt;
  logic [NUM_LINES-1:0] valid_r, valid_nxt;
  logic [NUM_WAYS-1:0]  way_dirty_r, way_dirty_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 o_hit_r, o_hit_nxt;
  logic [WAY_W-1:0]     o_way_r, o_way_nxt;
  logic                 o_wb_r, o_wb_nxt;
  logic [BLK_W-1:0]     o_wb_block_r, o_wb_block_nxt;
  logic [BLK_W-1:0]     o_block_r, o_block_nxt;
  logic                 o_store_r, o_store_nxt;

  logic [LINE_W-1:0]    line;
  logic                 ram_we;
  logic                 ram_re;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     ram_rdata;
  logic [TAG_W-1:0]     rd_tag;
  logic                 probe_hit;
  logic                 in_fire;
  logic                 out_free;
  logic [WAY_W-1:0]     lfsr_way;

  assign line      = (LINE_W'(set_r) << WAY_BITS) | LINE_W'(cur_way_r);
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign rd_tag    = ram_rdata[TAG_W-1:0];
  assign probe_hit = valid_r[line] && (rd_tag == tag_r);
  assign ram_we    = (state_r == S_FILL) || ((state_r == S_CMP) && probe_hit && is_write_r);
  assign ram_wdata = {(state_r == S_CMP), tag_r};
  assign ram_re    = (state_r == S_PROBE) || (state_r == S_VREAD);
  assign lfsr_way  = WAY_W'(lfsr_r) & WAY_MASK;

  sacd_ram #(
    .WIDTH  (ENT_W),
    .DEPTH  (NUM_LINES),
    .ADDR_W (LINE_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (line),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (line),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    is_write_nxt   = is_write_r;
    tag_nxt        = tag_r;
    set_nxt        = set_r;
    block_nxt      = block_r;
    cur_way_nxt    = cur_way_r;
    inv_found_nxt  = inv_found_r;
    inv_way_nxt    = inv_way_r;
    hit_nxt        = hit_r;
    wb_nxt         = wb_r;
    wb_block_nxt   = wb_block_r;
    lfsr_nxt       = lfsr_r;
    valid_nxt      = valid_r;
    way_dirty_nxt  = way_dirty_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    o_hit_nxt      = o_hit_r;
    o_way_nxt      = o_way_r;
    o_wb_nxt       = o_wb_r;
    o_wb_block_nxt = o_wb_block_r;
    o_block_nxt    = o_block_r;
    o_store_nxt    = o_store_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          is_write_nxt  = in_command;
          tag_nxt       = TAG_W'(in_address >> (SET_BITS + BLOCK_BITS));
          set_nxt       = SET_W'(in_address >> BLOCK_BITS) & SET_MASK;
          block_nxt     = in_address[ADDR_BITS-1:BLOCK_BITS];
          cur_way_nxt   = '0;
          inv_found_nxt = 1'b0;
          inv_way_nxt   = '0;
          hit_nxt       = 1'b0;
          wb_nxt        = 1'b0;
          wb_block_nxt  = '0;
          state_nxt     = S_PROBE;
        end
      end
      S_PROBE: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        way_dirty_nxt[cur_way_r] = ram_rdata[TAG_W];
        if (probe_hit) begin
          hit_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          if (!valid_r[line] && !inv_found_r) begin
            inv_found_nxt = 1'b1;
            inv_way_nxt   = cur_way_r;
          end
          if (cur_way_r == WAY_LAST) begin
            state_nxt = S_MISS;
          end else begin
            cur_way_nxt = cur_way_r + 1'b1;
            state_nxt   = S_PROBE;
          end
        end
      end
      S_MISS: begin
        if (inv_found_r) begin
          cur_way_nxt = inv_way_r;
          state_nxt   = S_FILL;
        end else begin
          cur_way_nxt = lfsr_way;
          lfsr_nxt    = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : '0);
          if (way_dirty_r[lfsr_way]) begin
            state_nxt = S_VREAD;
          end else begin
            state_nxt = S_FILL;
          end
        end
      end
      S_VREAD: begin
        state_nxt = S_VCAP;
      end
      S_VCAP: begin
        wb_nxt       = 1'b1;
        wb_block_nxt = BLK_W'((WB_W'(rd_tag) << SET_BITS) | WB_W'(set_r));
        state_nxt    = S_FILL;
      end
      S_FILL: begin
        valid_nxt[line] = 1'b1;
        state_nxt       = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          o_hit_nxt      = hit_r;
          o_way_nxt      = cur_way_r;
          o_wb_nxt       = wb_r;
          o_wb_block_nxt = wb_block_r;
          o_block_nxt    = block_r;
          o_store_nxt    = !hit_r && is_write_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lfsr_r      <= LFSR_SEED;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lfsr_r      <= lfsr_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_write_r   <= is_write_nxt;
    tag_r        <= tag_nxt;
    set_r        <= set_nxt;
    block_r      <= block_nxt;
    cur_way_r    <= cur_way_nxt;
    inv_found_r  <= inv_found_nxt;
    inv_way_r    <= inv_way_nxt;
    hit_r        <= hit_nxt;
    wb_r         <= wb_nxt;
    wb_block_r   <= wb_block_nxt;
    way_dirty_r  <= way_dirty_nxt;
    o_hit_r      <= o_hit_nxt;
    o_way_r      <= o_way_nxt;
    o_wb_r       <= o_wb_nxt;
    o_wb_block_r <= o_wb_block_nxt;
    o_block_r    <= o_block_nxt;
    o_store_r    <= o_store_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = o_hit_r;
  assign out_way             = OUT_WAY_W'(o_way_r);
  assign out_writeback       = o_wb_r;
  assign out_writeback_block = o_wb_block_r;
  assign out_fetch           = !o_hit_r;
  assign out_fetch_block     = o_block_r;
  assign out_store_through   = o_store_r;

endmodule
`default_nettype wire

[verif/set_assoc_cache_directory_top_tb.sv]
// Self-checking testbench for the set-associative cache directory top level.
// A scoreboard class tracks tags, valid and dirty bits and the victim LFSR.
// Depends on sacd_pkg and set_assoc_cache_directory_top.
`default_nettype none
module set_assoc_cache_directory_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_W   = sacd_pkg::SET_BITS_DEF;
  localparam int WAY_W   = sacd_pkg::WAY_BITS_DEF;
  localparam int OFF_W   = sacd_pkg::BLOCK_BITS_DEF;
  localparam int ADDR_W  = sacd_pkg::ADDR_BITS_DEF;
  localparam int TAG_W   = ADDR_W - SET_W - OFF_W;
  localparam int BLK_W   = ADDR_W - OFF_W;
  localparam int WAYS    = 1 << WAY_W;
  localparam int LINES   = 1 << (SET_W + WAY_W);
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_PER_PHASE = 440;
  localparam int HOLD_ITEMS = 40;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct {
    logic                           hit;
    logic [sacd_pkg::OUT_WAY_W-1:0] way;
    logic                           writeback;
    logic [BLK_W-1:0]               writeback_block;
    logic                           fetch;
    logic [BLK_W-1:0]               fetch_block;
    logic                           store_through;
  } dir_result_t;

  class directory_scoreboard;
    logic [TAG_W-1:0]           line_tag [LINES];
    bit                         line_valid [LINES];
    bit                         line_dirty [LINES];
    logic [sacd_pkg::LFSR_W-1:0] victim_lfsr;
    dir_result_t                predicted_q[$];
    int mismatches;
    int accesses;
    int hits;
    int evictions;
    int writebacks;

    function new();
      foreach (line_tag[i]) begin
        line_tag[i] = '0;
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
      end
      victim_lfsr = sacd_pkg::LFSR_SEED;
      mismatches = 0;
      accesses = 0;
      hits = 0;
      evictions = 0;
      writebacks = 0;
    endfunction

    function int outstanding();
      return predicted_q.size();
    endfunction

    function void note_access(logic cmd, logic [ADDR_W-1:0] addr);
      dir_result_t r;
      logic [SET_W-1:0] set_idx;
      logic [TAG_W-1:0] tag;
      int base;
      int w;
      int line;
      bit found;
      bit lsb;
      set_idx = addr[OFF_W +: SET_W];
      tag = addr[ADDR_W-1 -: TAG_W];
      base = int'(set_idx) * WAYS;
      found = 1'b0;
      r.writeback = 1'b0;
      r.writeback_block = '0;
      for (w = 0; w < WAYS; w++) begin
        if (line_valid[base + w] && line_tag[base + w] == tag) begin
          found = 1'b1;
          break;
        end
      end
      if (found) begin
        hits++;
        if (cmd == CMD_WRITE) line_dirty[base + w] = 1'b1;
      end else begin
        for (w = 0; w < WAYS; w++)
          if (!line_valid[base + w]) break;
        if (w == WAYS) begin
          evictions++;
          w = int'(victim_lfsr[WAY_W-1:0]);
          lsb = victim_lfsr[0];
          victim_lfsr = victim_lfsr >> 1;
          if (lsb) victim_lfsr = victim_lfsr ^ sacd_pkg::LFSR_TAPS;
          if (line_dirty[base + w]) begin
            writebacks++;
            r.writeback = 1'b1;
            r.writeback_block = {line_tag[base + w], set_idx};
          end
        end
        line = base + w;
        line_tag[line] = tag;
        line_valid[line] = 1'b1;
        line_dirty[line] = 1'b0;
      end
      r.hit = found;
      r.way = w[sacd_pkg::OUT_WAY_W-1:0];
      r.fetch = !found;
      r.fetch_block = addr[ADDR_W-1:OFF_W];
      r.store_through = !found && (cmd == CMD_WRITE);
      accesses++;
      predicted_q.push_back(r);
    endfunction

    task report_mismatch(string what, longint unsigned want, longint unsigned got);
      if (mismatches < 50)
        $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatches++;
    endtask

    task check_result(dir_result_t got);
      dir_result_t want;
      if (predicted_q.size() == 0) begin
        report_mismatch("unexpected word", 0, 1);
      end else begin
        want = predicted_q.pop_front();
        if (got.hit !== want.hit) report_mismatch("hit", want.hit, got.hit);
        if (got.way !== want.way) report_mismatch("way", want.way, got.way);
        if (got.writeback !== want.writeback)
          report_mismatch("writeback", want.writeback, got.writeback);
        if (got.writeback_block !== want.writeback_block)
          report_mismatch("writeback_block", want.writeback_block, got.writeback_block);
        if (got.fetch !== want.fetch) report_mismatch("fetch", want.fetch, got.fetch);
        if (got.fetch_block !== want.fetch_block)
          report_mismatch("fetch_block", want.fetch_block, got.fetch_block);
        if (got.store_through !== want.store_through)
          report_mismatch("store_through", want.store_through, got.store_through);
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_command = CMD_READ;
  logic [ADDR_W-1:0] in_address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_hit;
  logic [sacd_pkg::OUT_WAY_W-1:0] out_way;
  logic              out_writeback;
  logic [BLK_W-1:0]  out_writeback_block;
  logic              out_fetch;
  logic [BLK_W-1:0]  out_fetch_block;
  logic              out_store_through;

  int unsigned cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_asks = 0;
  int          hold_done = 0;
  logic [SET_W-1:0] hot_sets [4];
  logic [TAG_W-1:0] tag_pool [6];
  directory_scoreboard sb = new();

  set_assoc_cache_directory_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_address          (in_address),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit             (out_hit),
    .out_way             (out_way),
    .out_writeback       (out_writeback),
    .out_writeback_block (out_writeback_block),
    .out_fetch           (out_fetch),
    .out_fetch_block     (out_fetch_block),
    .out_store_through   (out_store_through)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d words outstanding", cycle_count, sb.outstanding());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_access(in_command, in_address);
  end

  always @(posedge clk) begin
    dir_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.hit = out_hit;
      got.way = out_way;
      got.writeback = out_writeback;
      got.writeback_block = out_writeback_block;
      got.fetch = out_fetch;
      got.fetch_block = out_fetch_block;
      got.store_through = out_store_through;
      sb.check_result(got);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [ADDR_W-1:0] make_addr(logic [TAG_W-1:0] tag,
                                                  logic [SET_W-1:0] set_idx,
                                                  logic [OFF_W-1:0] offset);
    return {tag, set_idx, offset};
  endfunction

  function automatic logic [ADDR_W-1:0] rand_address();
    if ($urandom_range(99) < 80)
      return make_addr(tag_pool[$urandom_range(5)], hot_sets[$urandom_range(3)],
                       OFF_W'($urandom_range((1 << OFF_W) - 1)));
    return $urandom();
  endfunction

  task automatic send_word(logic cmd, logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_word($urandom_range(1) ? CMD_WRITE : CMD_READ, rand_address());
  endtask

  initial begin
    hot_sets[0] = '0;
    hot_sets[1] = '1;
    hot_sets[2] = SET_W'($urandom());
    hot_sets[3] = SET_W'($urandom());
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 6; i++) tag_pool[i] = TAG_W'($urandom());

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // read miss, read hit, write hit, write miss, read hit at the address extremes
    send_word(CMD_READ, 32'h0000_0000);
    send_word(CMD_READ, 32'h0000_003F);
    send_word(CMD_WRITE, 32'h0000_0003);
    send_word(CMD_WRITE, 32'hFFFF_FFFF);
    send_word(CMD_READ, 32'hFFFF_FFFC);
    // fill set 0, dirty two ways, then force victims out of a full set
    send_word(CMD_WRITE, make_addr(20'd1, '0, '0));
    send_word(CMD_READ, make_addr(20'd2, '0, 6'd4));
    send_word(CMD_READ, make_addr(20'd3, '0, 6'd8));
    send_word(CMD_WRITE, make_addr(20'd2, '0, '0));
    send_word(CMD_WRITE, make_addr(20'd3, '0, '0));
    for (int t = 4; t < 12; t++)
      send_word(t[0] ? CMD_WRITE : CMD_READ, make_addr(TAG_W'(t), '0, OFF_W'(t)));
    send_word(CMD_READ, make_addr('1, '0, '1));
    wait_drained();

    // hold the receiver off while words keep coming
    hold_asks <= hold_asks + 1;
    send_random(HOLD_ITEMS);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      send_random(RAND_PER_PHASE);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d accesses: %0d hits, %0d misses, %0d full-set evictions, %0d write-backs",
             sb.accesses, sb.hits, sb.accesses - sb.hits, sb.evictions, sb.writebacks);
    $display("Idle and stall mixes plus one long receiver hold; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
